### hdl/radar_point_clip_project_defines.svh
// assertion helpers shared by the rtl
`ifndef RADAR_POINT_CLIP_PROJECT_DEFINES_SVH
`define RADAR_POINT_CLIP_PROJECT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

    // default widths
    localparam int COORD_BITS_DEF = 24;
    localparam int PIXEL_BITS_DEF = 16;

    // fixed field widths
    localparam int PIX_OUT_BITS  = 16;
    localparam int SCALE_BITS    = 16;
    localparam int TRIG_BITS     = 16;
    localparam int TRIG_FRAC     = 14;
    localparam int MARKER_BITS   = 16;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int MODE_BITS     = 3;
    localparam int REG_IDX_BITS  = 3;

    // quotient bits: projected value is below 4.5 times the view size
    localparam int QUO_BITS = 19;

    // arithmetic stages ahead of the divider
    localparam int FRONT_STAGES = 5;

    // anchor offset is 2.5 spans, i.e. 5 * radar size in Q.14
    localparam int ANCHOR_MULT = 5;
    localparam int ANCHOR_BITS = 3;

    // unit rotation: cos 0, sin 1.0 in Q1.14
    localparam logic signed [TRIG_BITS-1:0] ONE_Q14 = 16'sh4000;

    // mode flag bit positions
    localparam int MODE_Z_CLIP = 0;
    localparam int MODE_CIRCLE = 1;
    localparam int MODE_ROTATE = 2;

    // reset values
    localparam int          RADAR_SIZE_RST  = 25600;
    localparam int          RADAR_SIZE_ZERO = 256;
    localparam int          Z_LOW_RST       = -2560;
    localparam int          Z_HIGH_RST      = 2560;
    localparam logic [31:0] ROT_CS_RST      = 32'h4000_0000;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_MODE,
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_RADAR_SIZE,
        REG_Z_LOW,
        REG_Z_HIGH,
        REG_ROT_CS,
        REG_VIEW_SIZE
    } t_reg_idx;

    typedef struct packed {
        logic                    visible;
        logic [PIX_OUT_BITS-1:0] left;
        logic [PIX_OUT_BITS-1:0] top;
    } t_pix_word;

endpackage

`default_nettype wire

### hdl/radar_point_clip_project.sv
// channel | handshake           | payload
// --------+---------------------+------------------------------------------------
// input   | i_valid / o_stall   | i_point_x, i_point_y, i_point_z, i_marker_size
// output  | o_valid / i_stall   | o_visible, o_pixel_left, o_pixel_top
// config  | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// one word accepted per cycle while o_stall is low; each word passes through
// five arithmetic stages, one stage per bit of the 19-bit quotient and the output register
// the divider is a chain of compare-subtract stages, one quotient bit each
// reset is synchronous and active low; it clears valid bits and config registers
// an output register plus one skid word sit behind the pipeline; the pipeline
// and the input hold only while the skid word is occupied
`timescale 1ns / 1ps
`default_nettype none
`include "radar_point_clip_project_defines.svh"

module radar_point_clip_project import rpc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input words
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic [MARKER_BITS-1:0]       i_marker_size,
    // output words
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_visible,
    output logic signed [PIX_OUT_BITS-1:0] o_pixel_left,
    output logic signed [PIX_OUT_BITS-1:0] o_pixel_top,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0]     pwdata,
    output logic [APB_DATA_BITS-1:0]     prdata,
    output logic                         pready
);

    localparam int CB    = COORD_BITS;
    localparam int RSW   = CB - 1;                       // radar size
    localparam int DW    = CB + 1;                       // offset from origin
    localparam int PW    = DW + TRIG_BITS;               // rotation product
    localparam int RW    = PW + 1;                       // rotated coordinate
    localparam int SQW   = 2 * DW;                       // square
    localparam int D2W   = SQW + 1;                      // squared distance
    localparam int RRW   = 2 * RSW;                      // radar size squared
    localparam int DVW   = RSW + TRIG_FRAC + 1;          // divisor, span in Q.14
    localparam int KW    = RSW + ANCHOR_BITS + TRIG_FRAC; // anchor offset
    localparam int AW    = DVW + 3;                      // anchored numerator
    localparam int NW    = AW + SCALE_BITS;              // scaled numerator
    localparam int QW    = QUO_BITS;
    localparam int OW    = QW + 2;
    localparam int HW    = MARKER_BITS - 1;
    localparam int NPIPE = FRONT_STAGES + QW;

    localparam logic signed [OW-1:0] PIX_HI = OW'((1 << (PIXEL_BITS - 1)) - 1);
    localparam logic signed [OW-1:0] PIX_LO = OW'(-(1 << (PIXEL_BITS - 1)));

    // configuration registers
    logic [MODE_BITS-1:0]     r_mode;
    logic signed [CB-1:0]     r_origin_x;
    logic signed [CB-1:0]     r_origin_y;
    logic [RSW-1:0]           r_radar_size;
    logic signed [CB-1:0]     r_z_low;
    logic signed [CB-1:0]     r_z_high;
    logic [APB_DATA_BITS-1:0] r_rot_cs;
    logic [APB_DATA_BITS-1:0] r_view;

    logic w_cfg_wr;
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= '0;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_radar_size <= RSW'(RADAR_SIZE_RST);
            r_z_low      <= CB'(Z_LOW_RST);
            r_z_high     <= CB'(Z_HIGH_RST);
            r_rot_cs     <= ROT_CS_RST;
            r_view       <= '0;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[APB_ADDR_BITS-1:2]))
                REG_MODE:       r_mode       <= pwdata[MODE_BITS-1:0];
                REG_ORIGIN_X:   r_origin_x   <= pwdata[CB-1:0];
                REG_ORIGIN_Y:   r_origin_y   <= pwdata[CB-1:0];
                REG_RADAR_SIZE: r_radar_size <= pwdata[RSW-1:0];
                REG_Z_LOW:      r_z_low      <= pwdata[CB-1:0];
                REG_Z_HIGH:     r_z_high     <= pwdata[CB-1:0];
                REG_ROT_CS:     r_rot_cs     <= pwdata;
                REG_VIEW_SIZE:  r_view       <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (t_reg_idx'(paddr[APB_ADDR_BITS-1:2]))
            REG_MODE:       prdata = APB_DATA_BITS'(r_mode);
            REG_ORIGIN_X:   prdata = APB_DATA_BITS'($unsigned(r_origin_x));
            REG_ORIGIN_Y:   prdata = APB_DATA_BITS'($unsigned(r_origin_y));
            REG_RADAR_SIZE: prdata = APB_DATA_BITS'(r_radar_size);
            REG_Z_LOW:      prdata = APB_DATA_BITS'($unsigned(r_z_low));
            REG_Z_HIGH:     prdata = APB_DATA_BITS'($unsigned(r_z_high));
            REG_ROT_CS:     prdata = r_rot_cs;
            REG_VIEW_SIZE:  prdata = r_view;
            default:        prdata = '0;
        endcase
    end

    // values derived from the configuration
    logic [RSW-1:0]          w_r;
    logic signed [DW-1:0]    w_rs;
    logic [DVW-1:0]          w_d;
    logic [SCALE_BITS-1:0]   w_view_w;
    logic [SCALE_BITS-1:0]   w_view_h;
    logic signed [TRIG_BITS-1:0] w_cos;
    logic signed [TRIG_BITS-1:0] w_sin;
    logic [RRW-1:0]          r_rr;
    logic [KW-1:0]           r_k;

    // zero radar size stands for 1.0
    assign w_r  = (r_radar_size == '0) ? RSW'(RADAR_SIZE_ZERO) : r_radar_size;
    assign w_rs = signed'(DW'(w_r));
    // full span in Q.14
    assign w_d  = {w_r, {(TRIG_FRAC + 1){1'b0}}};
    assign w_view_w = r_view[APB_DATA_BITS-1:SCALE_BITS];
    assign w_view_h = r_view[SCALE_BITS-1:0];

    // without rotation the point goes through as cos 0, sin 1.0
    assign w_cos = r_mode[MODE_ROTATE] ? signed'(r_rot_cs[APB_DATA_BITS-1:TRIG_BITS]) : '0;
    assign w_sin = r_mode[MODE_ROTATE] ? signed'(r_rot_cs[TRIG_BITS-1:0]) : ONE_Q14;

    always_ff @(posedge i_clk) begin
        r_rr <= RRW'(w_r) * RRW'(w_r);
        r_k  <= {(RSW + ANCHOR_BITS)'(w_r) * (RSW + ANCHOR_BITS)'(ANCHOR_MULT),
                 {TRIG_FRAC{1'b0}}};
    end

    // pipeline control
    logic [NPIPE-1:0] r_vld;
    logic             r_skid_vld;
    logic             r_out_vld;
    logic             w_en;
    logic             w_fin_vld;

    assign w_en      = !r_skid_vld;
    assign o_stall   = r_skid_vld;
    assign w_fin_vld = r_vld[NPIPE-1] && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NPIPE-2:0], i_valid};
        end
    end

    // stage 1: offsets from the origin and z window
    logic signed [DW-1:0] n1_dx, n1_dy, r1_dx, r1_dy;
    logic                 n1_zok, r1_zok;
    logic [HW-1:0]        r1_half;

    assign n1_dx  = DW'(i_point_x) - DW'(r_origin_x);
    assign n1_dy  = DW'(i_point_y) - DW'(r_origin_y);
    assign n1_zok = !r_mode[MODE_Z_CLIP] ||
                    !((i_point_z < r_z_low) || (i_point_z > r_z_high));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx   <= n1_dx;
            r1_dy   <= n1_dy;
            r1_zok  <= n1_zok;
            r1_half <= i_marker_size[MARKER_BITS-1:1];
        end
    end

    // stage 2: squares, rotation products, box tests
    logic signed [SQW-1:0] r2_sqx, r2_sqy;
    logic signed [PW-1:0]  r2_pyc, r2_pxs, r2_pys, r2_pxc;
    logic                  n2_box, n2_inner, n2_vis, r2_vis;
    logic [HW-1:0]         r2_half;

    assign n2_box   = (r1_dx <= w_rs) && (r1_dx >= -w_rs) &&
                      (r1_dy <= w_rs) && (r1_dy >= -w_rs);
    assign n2_inner = (r1_dx < w_rs) && (r1_dx > -w_rs) &&
                      (r1_dy < w_rs) && (r1_dy > -w_rs);
    assign n2_vis   = r1_zok && (r_mode[MODE_CIRCLE] ? n2_inner : n2_box);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sqx  <= SQW'(r1_dx) * SQW'(r1_dx);
            r2_sqy  <= SQW'(r1_dy) * SQW'(r1_dy);
            r2_pyc  <= PW'(r1_dy) * PW'(w_cos);
            r2_pxs  <= PW'(r1_dx) * PW'(w_sin);
            r2_pys  <= PW'(r1_dy) * PW'(w_sin);
            r2_pxc  <= PW'(r1_dx) * PW'(w_cos);
            r2_vis  <= n2_vis;
            r2_half <= r1_half;
        end
    end

    // stage 3: circle test and rotated coordinates
    logic signed [D2W-1:0] n3_d2;
    logic                  n3_vis, r3_vis;
    logic signed [RW-1:0]  r3_rx, r3_ry;
    logic [HW-1:0]         r3_half;

    assign n3_d2  = D2W'(r2_sqx) + D2W'(r2_sqy);
    assign n3_vis = r2_vis && (!r_mode[MODE_CIRCLE] || (n3_d2 < signed'(D2W'(r_rr))));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_rx   <= RW'(r2_pyc) + RW'(r2_pxs);
            r3_ry   <= RW'(r2_pys) - RW'(r2_pxc);
            r3_vis  <= n3_vis;
            r3_half <= r2_half;
        end
    end

    // stage 4: move the numerator into the non-negative range
    logic [RW-1:0] n4_ax, n4_ay;
    logic [AW-1:0] r4_ax, r4_ay;
    logic          r4_vis;
    logic [HW-1:0] r4_half;

    assign n4_ax = $unsigned(r3_rx) + RW'(r_k);
    assign n4_ay = $unsigned(r3_ry) + RW'(r_k);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ax   <= n4_ax[AW-1:0];
            r4_ay   <= n4_ay[AW-1:0];
            r4_vis  <= r3_vis;
            r4_half <= r3_half;
        end
    end

    // stage 5: scale to the view
    logic [NW-1:0] r5_nx, r5_ny;
    logic          r5_vis;
    logic [HW-1:0] r5_half;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_nx   <= NW'(r4_ax) * NW'(w_view_w);
            r5_ny   <= NW'(r4_ay) * NW'(w_view_h);
            r5_vis  <= r4_vis;
            r5_half <= r4_half;
        end
    end

    // divider: one quotient bit per stage, both lanes side by side
    logic [NW-1:0] r_dv_remx [QW];
    logic [NW-1:0] r_dv_remy [QW];
    logic [QW-1:0] r_dv_qx   [QW];
    logic [QW-1:0] r_dv_qy   [QW];
    logic          r_dv_vis  [QW];
    logic [HW-1:0] r_dv_half [QW];

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int BIT = QW - 1 - j;

        logic [NW-1:0] w_remx_in, w_remy_in;
        logic [QW-1:0] w_qx_in, w_qy_in;
        logic          w_vis_in;
        logic [HW-1:0] w_half_in;
        logic [NW:0]   w_dsh, w_tx, w_ty;
        logic [QW-1:0] n_qx, n_qy;

        if (j == 0) begin : g_first
            assign w_remx_in = r5_nx;
            assign w_remy_in = r5_ny;
            assign w_qx_in   = '0;
            assign w_qy_in   = '0;
            assign w_vis_in  = r5_vis;
            assign w_half_in = r5_half;
        end else begin : g_rest
            assign w_remx_in = r_dv_remx[j-1];
            assign w_remy_in = r_dv_remy[j-1];
            assign w_qx_in   = r_dv_qx[j-1];
            assign w_qy_in   = r_dv_qy[j-1];
            assign w_vis_in  = r_dv_vis[j-1];
            assign w_half_in = r_dv_half[j-1];
        end

        // trial subtract of the shifted divisor
        assign w_dsh = (NW + 1)'(w_d) << BIT;
        assign w_tx  = {1'b0, w_remx_in} - w_dsh;
        assign w_ty  = {1'b0, w_remy_in} - w_dsh;

        always_comb begin
            n_qx      = w_qx_in;
            n_qy      = w_qy_in;
            n_qx[BIT] = !w_tx[NW];
            n_qy[BIT] = !w_ty[NW];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_remx[j] <= w_tx[NW] ? w_remx_in : w_tx[NW-1:0];
                r_dv_remy[j] <= w_ty[NW] ? w_remy_in : w_ty[NW-1:0];
                r_dv_qx[j]   <= n_qx;
                r_dv_qy[j]   <= n_qy;
                r_dv_vis[j]  <= w_vis_in;
                r_dv_half[j] <= w_half_in;
            end
        end
    end

    // undo the anchor, subtract half the marker, truncate toward zero, saturate
    function automatic logic [PIX_OUT_BITS-1:0] f_pixel(
        input logic [QW-1:0]         q,
        input logic [SCALE_BITS-1:0] scale,
        input logic [HW-1:0]         half,
        input logic                  rem_nz
    );
        logic signed [OW-1:0] t;
        logic signed [OW-1:0] u;
        t = signed'(OW'(q)) - signed'(OW'({scale, 1'b0})) - signed'(OW'(half));
        u = t + signed'(OW'(t[OW-1] && rem_nz));
        if (u > PIX_HI) begin
            u = PIX_HI;
        end else if (u < PIX_LO) begin
            u = PIX_LO;
        end
        return u[PIX_OUT_BITS-1:0];
    endfunction

    t_pix_word n_fin;
    t_pix_word r_out;
    t_pix_word r_skid;

    always_comb begin
        n_fin.visible = r_dv_vis[QW-1];
        if (r_dv_vis[QW-1]) begin
            n_fin.left = f_pixel(r_dv_qx[QW-1], w_view_w, r_dv_half[QW-1],
                                 r_dv_remx[QW-1] != '0);
            n_fin.top  = f_pixel(r_dv_qy[QW-1], w_view_h, r_dv_half[QW-1],
                                 r_dv_remy[QW-1] != '0);
        end else begin
            n_fin.left = '0;
            n_fin.top  = '0;
        end
    end

    // output register and skid word control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || !i_stall) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= w_fin_vld;
            end
        end else if (w_fin_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    // output register and skid word data
    always_ff @(posedge i_clk) begin
        if (!r_out_vld || !i_stall) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (w_fin_vld) begin
                r_out <= n_fin;
            end
        end else if (w_fin_vld) begin
            r_skid <= n_fin;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_visible    = r_out.visible;
    assign o_pixel_left = signed'(r_out.left);
    assign o_pixel_top  = signed'(r_out.top);

    // checks
    `RPC_ASSERT_IMP(a_skid_has_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid word without output word")
    `RPC_ASSERT_IMP(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_vld), $past(r_out_vld) && $past(i_stall), "skid filled without a stalled output")
    `RPC_ASSERT_NXT(a_pipe_frozen, i_clk, i_rst_n, r_skid_vld, $stable(r_vld), "pipeline moved while skid word held")
    `RPC_ASSERT_IMP(a_hidden_zero, i_clk, i_rst_n, r_out_vld && !r_out.visible, (r_out.left == '0) && (r_out.top == '0), "hidden word with non-zero pixels")

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench import rpc_pkg::*; ();

    localparam int CW             = COORD_BITS_DEF;
    localparam int SETTLE_CYCLES  = 30;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int WORDS_PER_SET  = 95;
    localparam int SETS_PER_PHASE = 6;

    // mode flag values
    localparam logic [MODE_BITS-1:0] FLAG_Z_CLIP = MODE_BITS'(1 << MODE_Z_CLIP);
    localparam logic [MODE_BITS-1:0] FLAG_CIRCLE = MODE_BITS'(1 << MODE_CIRCLE);
    localparam logic [MODE_BITS-1:0] FLAG_ROTATE = MODE_BITS'(1 << MODE_ROTATE);

    typedef struct {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [CW-1:0]    z;
        logic [MARKER_BITS-1:0]  marker;
    } t_point;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                     i_valid       = 1'b0;
    logic                     o_stall;
    logic signed [CW-1:0]     i_point_x     = '0;
    logic signed [CW-1:0]     i_point_y     = '0;
    logic signed [CW-1:0]     i_point_z     = '0;
    logic [MARKER_BITS-1:0]   i_marker_size = '0;
    logic                     o_valid;
    logic                     i_stall       = 1'b0;
    logic                     o_visible;
    logic signed [PIX_OUT_BITS-1:0] o_pixel_left;
    logic signed [PIX_OUT_BITS-1:0] o_pixel_top;
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr         = '0;
    logic [APB_DATA_BITS-1:0] pwdata        = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // register copies for the predictor
    logic [MODE_BITS-1:0] cfg_mode     = '0;
    logic signed [CW-1:0] cfg_org_x    = '0;
    logic signed [CW-1:0] cfg_org_y    = '0;
    logic [CW-2:0]        cfg_radar    = (CW - 1)'(RADAR_SIZE_RST);
    logic signed [CW-1:0] cfg_z_low    = CW'(Z_LOW_RST);
    logic signed [CW-1:0] cfg_z_high   = CW'(Z_HIGH_RST);
    logic [31:0]          cfg_rot      = ROT_CS_RST;
    logic [31:0]          cfg_view     = '0;

    t_point    pending_points[$];
    t_pix_word expected_pixels[$];
    bit        word_taken     = 1'b0;
    int        send_gap_pct   = 24;
    int        recv_gap_pct   = 48;
    int        mismatch_count = 0;
    int        stuck_cycles   = 0;

    radar_point_clip_project dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_marker_size (i_marker_size),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_visible     (o_visible),
        .o_pixel_left  (o_pixel_left),
        .o_pixel_top   (o_pixel_top),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // exact trunc((a * scale - half * d) / d) for d > 0
    function automatic longint scale_trunc(longint a, longint d, longint scale, longint half);
        longint q1, rem, q2;
        q1 = a / d;
        if ((a % d) != 0 && a < 0)
            q1 = q1 - 1;
        rem = (a - q1 * d) * scale;
        q2 = q1 * scale - half + rem / d;
        if (q2 < 0 && (rem % d) != 0)
            q2 = q2 + 1;
        return q2;
    endfunction

    function automatic logic [PIX_OUT_BITS-1:0] clamp_pixel(longint v);
        longint hi, lo;
        hi = (longint'(1) << (PIXEL_BITS_DEF - 1)) - 1;
        lo = -(longint'(1) << (PIXEL_BITS_DEF - 1));
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return PIX_OUT_BITS'(v);
    endfunction

    // clip and project one point with the current register copies
    function automatic t_pix_word predict_pixels(t_point p);
        longint dx, dy, adx, ady, r, w, h, half, cosv, sinv, rs;
        logic shown;
        t_pix_word res;
        res = '0;
        r = (cfg_radar == '0) ? longint'(RADAR_SIZE_ZERO) : longint'(cfg_radar);
        w = longint'(cfg_view[31:16]);
        h = longint'(cfg_view[15:0]);
        half = longint'(p.marker >> 1);
        dx = longint'(p.x) - longint'(cfg_org_x);
        dy = longint'(p.y) - longint'(cfg_org_y);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        shown = !(cfg_mode[MODE_Z_CLIP] && (p.z < cfg_z_low || p.z > cfg_z_high));
        if (cfg_mode[MODE_CIRCLE]) begin
            if (adx >= r || ady >= r || adx * adx + ady * ady >= r * r)
                shown = 1'b0;
        end else if (adx > r || ady > r) begin
            shown = 1'b0;
        end
        if (!shown)
            return res;
        res.visible = 1'b1;
        if (cfg_mode[MODE_ROTATE]) begin
            cosv = longint'($signed(cfg_rot[31:16]));
            sinv = longint'($signed(cfg_rot[15:0]));
            rs = r << TRIG_FRAC;
            res.left = clamp_pixel(scale_trunc(dy * cosv + dx * sinv + rs, 2 * rs, w, half));
            res.top  = clamp_pixel(scale_trunc(dy * sinv - dx * cosv + rs, 2 * rs, h, half));
        end else begin
            res.left = clamp_pixel(scale_trunc(dx + r, 2 * r, w, half));
            res.top  = clamp_pixel(scale_trunc(dy + r, 2 * r, h, half));
        end
        return res;
    endfunction

    function automatic longint rand_between(longint lo, longint hi);
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    // mostly points near the radar window, some on its edges, some anywhere
    function automatic t_point random_point();
        t_point p;
        longint r, dx, dy, tmp, z, zl, zh;
        r = (cfg_radar == '0) ? longint'(RADAR_SIZE_ZERO) : longint'(cfg_radar);
        dx = rand_between(-r, r);
        dy = rand_between(-r, r);
        case ($urandom_range(9))
            0, 1: begin
                dx = longint'($urandom());
                dy = longint'($urandom());
            end
            2, 3: begin
                dx = ($urandom_range(1) ? r : -r) + rand_between(-1, 1);
                if ($urandom_range(1)) begin
                    tmp = dx;
                    dx = dy;
                    dy = tmp;
                end
            end
            4: begin
                dy = longint'($floor($sqrt(real'(r * r - dx * dx)))) + rand_between(-1, 1);
                if ($urandom_range(1))
                    dy = -dy;
            end
            default: ;
        endcase
        zl = longint'(cfg_z_low);
        zh = longint'(cfg_z_high);
        case ($urandom_range(7))
            0: z = zl;
            1: z = zh;
            2: z = zl - 1;
            3: z = zh + 1;
            4: z = longint'($urandom());
            default: z = (zl <= zh) ? rand_between(zl, zh) : rand_between(zh, zl);
        endcase
        p.x = CW'(longint'(cfg_org_x) + dx);
        p.y = CW'(longint'(cfg_org_y) + dy);
        p.z = CW'(z);
        p.marker = $urandom_range(1) ? MARKER_BITS'($urandom_range(63))
                                     : MARKER_BITS'($urandom_range(65535));
        return p;
    endfunction

    task automatic push_point(longint x, longint y, longint z, int marker);
        t_point p;
        p.x = CW'(x);
        p.y = CW'(y);
        p.z = CW'(z);
        p.marker = MARKER_BITS'(marker);
        pending_points.push_back(p);
    endtask

    // setup cycle, then access cycle until pready
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_BITS'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            REG_MODE:       cfg_mode   = val[MODE_BITS-1:0];
            REG_ORIGIN_X:   cfg_org_x  = val[CW-1:0];
            REG_ORIGIN_Y:   cfg_org_y  = val[CW-1:0];
            REG_RADAR_SIZE: cfg_radar  = val[CW-2:0];
            REG_Z_LOW:      cfg_z_low  = val[CW-1:0];
            REG_Z_HIGH:     cfg_z_high = val[CW-1:0];
            REG_ROT_CS:     cfg_rot    = val;
            REG_VIEW_SIZE:  cfg_view   = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold off until every word is back, then let the pipeline settle
    task automatic drain_pipeline();
        while (pending_points.size() != 0 || i_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] coord_word(longint v);
        return {8'h00, CW'(v)};
    endfunction

    // kind 0 and 1 give the two extreme settings, others are random
    task automatic random_settings(int kind);
        logic [31:0] mode, ox, oy, rad, zl, zh, rot, view, a, b;
        if (kind == 0) begin
            mode = 32'(FLAG_Z_CLIP | FLAG_CIRCLE | FLAG_ROTATE);
            ox = coord_word(8388607);
            oy = coord_word(-8388608);
            rad = 32'd8388607;
            zl = coord_word(-8388608);
            zh = coord_word(8388607);
            rot = 32'h8000_7fff;
            view = 32'hffff_ffff;
        end else if (kind == 1) begin
            mode = '0;
            ox = coord_word(-8388608);
            oy = coord_word(8388607);
            rad = 32'd1;
            zl = coord_word(8388607);
            zh = coord_word(-8388608);
            rot = 32'h7fff_8000;
            view = '0;
        end else begin
            mode = $urandom_range(7);
            ox = $urandom_range(1) ? coord_word(rand_between(-65536, 65536)) : $urandom();
            oy = $urandom_range(1) ? coord_word(rand_between(-65536, 65536)) : $urandom();
            case ($urandom_range(5))
                0: rad = 32'd0;
                1: rad = 32'd1;
                2: rad = RADAR_SIZE_ZERO;
                3: rad = $urandom_range(1, 65535);
                4: rad = $urandom_range(1, 8388607);
                default: rad = 32'd8388607;
            endcase
            a = coord_word(rand_between(-8388608, 8388607));
            b = coord_word(rand_between(-8388608, 8388607));
            if ($urandom_range(3) == 0) begin
                a = coord_word(rand_between(-4096, 4096));
                b = coord_word(rand_between(-4096, 4096));
            end
            // crossed bounds now and then
            if (($signed(a[CW-1:0]) > $signed(b[CW-1:0])) == ($urandom_range(7) != 0)) begin
                zl = b;
                zh = a;
            end else begin
                zl = a;
                zh = b;
            end
            case ($urandom_range(6))
                0: rot = ROT_CS_RST;
                1: rot = 32'h0000_4000;
                2: rot = 32'hc000_0000;
                3: rot = 32'h0000_c000;
                4: rot = 32'h2d41_2d41;
                5: rot = 32'h2d41_d2bf;
                default: rot = $urandom();
            endcase
            case ($urandom_range(3))
                0: view = '0;
                1: view = {16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000))};
                2: view = $urandom();
                default: view = 32'hffff_ffff;
            endcase
        end
        write_reg(REG_MODE, mode);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_RADAR_SIZE, rad);
        write_reg(REG_Z_LOW, zl);
        write_reg(REG_Z_HIGH, zh);
        write_reg(REG_ROT_CS, rot);
        write_reg(REG_VIEW_SIZE, view);
    endtask

    task automatic run_directed();
        // reset settings: zero view size
        push_point(0, 0, 0, 7);
        push_point(0, 0, 0, 65535);
        drain_pipeline();
        // box clip edges and coordinate extremes
        write_reg(REG_VIEW_SIZE, {16'd800, 16'd600});
        push_point(0, 0, 0, 0);
        push_point(25600, 25600, 0, 4);
        push_point(-25600, -25600, 0, 4);
        push_point(25601, 0, 0, 4);
        push_point(0, -25601, 0, 4);
        push_point(8388607, 8388607, 8388607, 65535);
        push_point(-8388608, -8388608, -8388608, 1);
        push_point(12345, -6789, 0, 65535);
        drain_pipeline();
        // circle clip strictness and inclusive z window
        write_reg(REG_MODE, 32'(FLAG_Z_CLIP | FLAG_CIRCLE));
        push_point(15360, 20480, 0, 2);
        push_point(15360, 20479, 0, 2);
        push_point(25599, 0, 0, 2);
        push_point(25600, 0, 0, 2);
        push_point(0, 0, -2560, 2);
        push_point(0, 0, 2560, 2);
        push_point(0, 0, -2561, 2);
        push_point(0, 0, 2561, 2);
        drain_pipeline();
        // crossed z bounds hide everything
        write_reg(REG_Z_LOW, coord_word(100));
        write_reg(REG_Z_HIGH, coord_word(-100));
        write_reg(REG_MODE, 32'(FLAG_Z_CLIP));
        push_point(0, 0, 0, 0);
        drain_pipeline();
        // zero radar size, rotation with extreme trig, pixel saturation
        write_reg(REG_MODE, 32'(FLAG_ROTATE));
        write_reg(REG_RADAR_SIZE, 32'd0);
        write_reg(REG_ROT_CS, 32'h7fff_8000);
        write_reg(REG_VIEW_SIZE, 32'hffff_ffff);
        push_point(256, 256, 0, 0);
        push_point(-256, -256, 0, 0);
        push_point(0, 0, 0, 0);
        drain_pipeline();
    endtask

    task automatic note_mismatch(string what, t_pix_word want, t_pix_word got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected vis %0b left %0d top %0d, got vis %0b left %0d top %0d",
                     what, want.visible, $signed(want.left), $signed(want.top),
                     got.visible, $signed(got.left), $signed(got.top));
    endtask

    // driver: new word only once the current one is taken
    always @(negedge i_clk) begin
        t_point nxt;
        i_stall <= (recv_gap_pct != 0) && ($urandom_range(99) < recv_gap_pct);
        if (!i_valid || word_taken) begin
            word_taken = 1'b0;
            if (pending_points.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                nxt = pending_points.pop_front();
                i_valid       <= 1'b1;
                i_point_x     <= nxt.x;
                i_point_y     <= nxt.y;
                i_point_z     <= nxt.z;
                i_marker_size <= nxt.marker;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: check returned words, predict accepted ones, watchdog
    always @(posedge i_clk) begin
        t_pix_word got, want;
        t_point    cur;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                got.visible = o_visible;
                got.left    = o_pixel_left;
                got.top     = o_pixel_top;
                if (expected_pixels.size() == 0) begin
                    note_mismatch("unexpected word", '0, got);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.visible !== want.visible || got.left !== want.left ||
                        got.top !== want.top)
                        note_mismatch("wrong word", want, got);
                end
            end
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                word_taken = 1'b1;
                cur.x = i_point_x;
                cur.y = i_point_y;
                cur.z = i_point_z;
                cur.marker = i_marker_size;
                expected_pixels.push_back(predict_pixels(cur));
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // reset, directed words, then random phases under three idling patterns
    initial begin
        int phase, k;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        for (phase = 0; phase < 3; phase++) begin
            send_gap_pct = (phase == 0) ? 24 : (phase == 1) ? 48 : 0;
            recv_gap_pct = (phase == 0) ? 48 : (phase == 1) ? 24 : 0;
            for (k = 0; k < SETS_PER_PHASE; k++) begin
                random_settings(k);
                repeat (WORDS_PER_SET) pending_points.push_back(random_point());
                drain_pipeline();
            end
        end
        mismatch_count += expected_pixels.size();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
